[src/crla_pkg.sv]
// ----------------------------------------------------------------------------
// crla_pkg: shared definitions for the CR-terminated line assembler
// Holds the terminator code, default capacity, the sequencer state type and
// the structures passed between the sequencer and the output stage.
// ----------------------------------------------------------------------------
package crla_pkg;

    localparam logic [7:0] CR_CODE = 8'd13;
    localparam int LINE_CAPACITY_DEF = 32;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } t_state;

    // Read issued to the line store this cycle; data returns next cycle.
    typedef struct packed {
        logic valid;
        logic last;
    } t_rd_req;

    // Output stage can absorb one more read issued this cycle.
    typedef struct packed {
        logic room;
    } t_out_stat;

endpackage

[src/crla_ram.sv]
// ----------------------------------------------------------------------------
// crla_ram: generic single-port synchronous RAM
// One address per cycle, write or read, with the read data registered.
// ----------------------------------------------------------------------------
module crla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/crla_ctrl.sv]
// ----------------------------------------------------------------------------
// crla_ctrl: line store sequencer
// Keeps the fill count and discard flag, writes incoming bytes into the line
// store and, on a terminator, walks the line out one read per unstalled cycle.
// ----------------------------------------------------------------------------
module crla_ctrl import crla_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    localparam int DEPTH = LINE_CAPACITY - 1,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(LINE_CAPACITY)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rx_valid,
    output logic          o_rx_ready,
    input  logic [7:0]    i_rx_byte,
    input  t_out_stat     i_out_stat,
    output t_rd_req       o_rd_req,
    output logic          o_we,
    output logic [AW-1:0] o_addr,
    output logic [7:0]    o_wdata
);

    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_state        r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_rd_ptr, n_rd_ptr;
    logic          r_discard, n_discard;

    logic accept;
    logic is_cr;
    logic rd_last;
    logic rd_issue;

    assign accept  = i_rx_valid && (r_state == ST_IDLE);
    assign is_cr   = (i_rx_byte == CR_CODE);
    assign rd_last = (r_rd_ptr == r_len - CW'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !r_discard && is_cr && (r_fill != '0)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (i_out_stat.room && rd_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_rx_ready = 1'b0;
        o_we       = 1'b0;
        rd_issue   = 1'b0;
        o_addr     = r_fill[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                o_rx_ready = 1'b1;
                o_we = accept && !r_discard && !is_cr && (r_fill != FULL);
            end
            ST_READ: begin
                rd_issue = i_out_stat.room;
                o_addr   = r_rd_ptr[AW-1:0];
            end
            default: ;
        endcase
        o_rd_req.valid = rd_issue;
        o_rd_req.last  = rd_last;
        o_wdata        = i_rx_byte;
    end

    // Datapath state.
    always_comb begin
        n_fill    = r_fill;
        n_len     = r_len;
        n_rd_ptr  = r_rd_ptr;
        n_discard = r_discard;
        if (accept) begin
            if (r_discard) begin
                if (is_cr) begin
                    n_discard = 1'b0;
                    n_fill    = '0;
                end
            end else if (is_cr) begin
                n_len    = r_fill;
                n_rd_ptr = '0;
                n_fill   = '0;
            end else if (r_fill != FULL) begin
                n_fill = r_fill + CW'(1);
            end else begin
                // Overflow: drop the line and swallow up to the next terminator.
                n_fill    = '0;
                n_discard = 1'b1;
            end
        end
        if (rd_issue) begin
            n_rd_ptr = r_rd_ptr + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_discard <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_discard <= n_discard;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_rd_ptr <= n_rd_ptr;
    end

endmodule

[src/crla_out.sv]
// ----------------------------------------------------------------------------
// crla_out: output buffer
// Catches line store read data in the cycle after the read and holds up to two
// items, so reads may be issued while the receiver stalls.
// ----------------------------------------------------------------------------
module crla_out import crla_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_rd_req    i_rd_req,
    input  logic [7:0] i_rdata,
    output t_out_stat  o_out_stat,
    output logic       o_line_valid,
    input  logic       i_line_ready,
    output logic [7:0] o_line_byte,
    output logic       o_line_end
);

    logic       r_pend, r_pend_last;
    logic [1:0] r_occ, n_occ;
    logic [7:0] r_d0, r_d1, n_d0, n_d1;
    logic       r_l0, r_l1, n_l0, n_l1;
    logic       pop;
    logic [1:0] occ_after;
    logic [2:0] committed;

    assign o_line_valid = (r_occ != 2'd0);
    assign o_line_byte  = r_d0;
    assign o_line_end   = r_l0;
    assign pop          = o_line_valid && i_line_ready;

    // Entries held plus the one still coming back from the store.
    assign committed       = 3'(r_occ) + 3'(r_pend);
    assign o_out_stat.room = (committed < 3'd2) || pop;

    always_comb begin
        n_d0      = r_d0;
        n_d1      = r_d1;
        n_l0      = r_l0;
        n_l1      = r_l1;
        occ_after = r_occ - 2'(pop);
        if (pop) begin
            n_d0 = r_d1;
            n_l0 = r_l1;
        end
        if (r_pend) begin
            if (occ_after == 2'd0) begin
                n_d0 = i_rdata;
                n_l0 = r_pend_last;
            end else begin
                n_d1 = i_rdata;
                n_l1 = r_pend_last;
            end
        end
        n_occ = occ_after + 2'(r_pend);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= 2'd0;
            r_pend <= 1'b0;
        end else begin
            r_occ  <= n_occ;
            r_pend <= i_rd_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_last <= i_rd_req.last;
        r_d0        <= n_d0;
        r_d1        <= n_d1;
        r_l0        <= n_l0;
        r_l1        <= n_l1;
    end

endmodule

[src/cr_terminated_line_assembler_core.sv]
// ----------------------------------------------------------------------------
// cr_terminated_line_assembler_core: CR-terminated line assembler
// Collects received bytes into a line store and emits each completed line.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on the rx channel (i_rx_valid / o_rx_ready /
// i_rx_byte). Bytes other than carriage return are written into the line
// store, one item per cycle while no readout is in progress. A carriage return
// after a non-empty line starts a readout: the stored bytes leave on the line
// channel (o_line_valid / i_line_ready / o_line_byte / o_line_end), in arrival
// order, with o_line_end set on the last one. Each byte passes through the
// store's read register and then the output buffer before it appears.
// A carriage return that closes a line holds the rx channel until every
// stored byte has been read, one store read per cycle through the single
// memory port while the two-item output buffer has room to take it.
// An empty line is ignored. A data byte arriving at a full store drops the line
// and everything up to and including the next carriage return.
// Reset clears the fill count, the discard flag and the output buffer;
// the store contents are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
module cr_terminated_line_assembler_core import crla_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_line_valid,
    input  logic       i_line_ready,
    output logic [7:0] o_line_byte,
    output logic       o_line_end
);

    localparam int DEPTH = LINE_CAPACITY - 1;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_rd_req       rd_req;
    t_out_stat     out_stat;
    logic          we;
    logic [AW-1:0] addr;
    logic [7:0]    wdata;
    logic [7:0]    rdata;

    crla_ctrl #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .i_out_stat (out_stat),
        .o_rd_req   (rd_req),
        .o_we       (we),
        .o_addr     (addr),
        .o_wdata    (wdata)
    );

    crla_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    crla_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_req     (rd_req),
        .i_rdata      (rdata),
        .o_out_stat   (out_stat),
        .o_line_valid (o_line_valid),
        .i_line_ready (i_line_ready),
        .o_line_byte  (o_line_byte),
        .o_line_end   (o_line_end)
    );

endmodule
